// ===== sv/vmu_pkg.sv =====
// ----------------------------------------------------------------------------
// vmu_pkg - vector math unit shared types and constants
// Opcodes, normalize sizes, square-root widths, lane side-band record and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package vmu_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_CROSS = 3'd3;
    localparam logic [2:0] OP_DOT   = 3'd4;
    localparam logic [2:0] OP_SCALE = 3'd5;
    localparam logic [2:0] OP_NORM  = 3'd6;

    localparam logic [2:0] SIZE_2 = 3'd2;
    localparam logic [2:0] SIZE_3 = 3'd3;
    localparam logic [2:0] SIZE_4 = 3'd4;

    // 65-bit sum of squares, padded to an even 66-bit radicand -> 33 root bits
    localparam int RAD_W    = 66;
    localparam int ROOT_W   = 33;
    localparam int SQ_STEPS = 33;
    localparam int REM_W    = 34;

    // per-beat record carried down the pipe
    typedef struct packed {
        logic             nrm;
        logic             fault;
        logic [3:0]       used;
        logic [3:0]       neg;
        logic [3:0][31:0] mag;
        logic [3:0][31:0] res;
    } side_t;

    function automatic logic [31:0] sat32(input logic [65:0] v);
        logic [31:0] r;
        if (&v[65:31] || ~|v[65:31]) begin
            r = v[31:0];
        end else if (v[65]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7fff_ffff;
        end
        return r;
    endfunction

endpackage

// ===== sv/vector_math_unit.sv =====
// ----------------------------------------------------------------------------
// vector_math_unit - four-lane Q-format vector ALU with normalize
// Lane add/sub/mul, cross, dot, scale and normalize, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while not stalled; the 33 square-root stages
// and the FRAC_BITS+1 divide stages each retire one bit per beat per cycle.
// Back pressure stalls the whole pipe in place; s_tready is high unless a
// finished beat waits at the output for m_tready.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
module vector_math_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (32 each), norm_size (3), pad
    input  logic [263:0] s_tdata,
    // req_type (3)
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r_x, r_y, r_z, r_w (32 each)
    output logic [127:0] m_tdata,
    // fault (1)
    output logic         m_tuser
);

    localparam int QW = FRAC_BITS + 1;   // quotient never exceeds 2^FRAC_BITS

    // global advance: the pipe moves unless a finished beat is stuck at the output
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage A: operand steering, add/sub, magnitudes, normalize size check
    // ------------------------------------------------------------------
    logic signed [31:0] a_in [4];
    logic signed [31:0] b_in [4];
    logic        [2:0]  size_in;
    logic signed [31:0] x0_next [4], y0_next [4], x1_next [4], y1_next [4];
    vmu_pkg::side_t     a_side_next;

    logic               a_vld_reg;
    logic        [2:0]  a_op_reg;
    logic signed [31:0] a_x0_reg [4], a_y0_reg [4], a_x1_reg [4], a_y1_reg [4];
    vmu_pkg::side_t     a_side_reg;

    always_comb begin
        logic [32:0] s33;
        for (int i = 0; i < 4; i++) begin
            a_in[i] = s_tdata[32*i +: 32];
            b_in[i] = s_tdata[128 + 32*i +: 32];
        end
        size_in = s_tdata[258:256];

        a_side_next = '0;
        for (int i = 0; i < 4; i++) begin
            x0_next[i] = '0;
            y0_next[i] = '0;
            x1_next[i] = '0;
            y1_next[i] = '0;
            a_side_next.neg[i] = a_in[i][31];
            a_side_next.mag[i] = a_in[i][31] ? (~a_in[i] + 32'd1) : a_in[i];
        end

        unique case (s_tuser)
            vmu_pkg::OP_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    s33 = {a_in[i][31], a_in[i]} + {b_in[i][31], b_in[i]};
                    a_side_next.res[i] = vmu_pkg::sat32({{33{s33[32]}}, s33});
                end
            end
            vmu_pkg::OP_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    s33 = {a_in[i][31], a_in[i]} - {b_in[i][31], b_in[i]};
                    a_side_next.res[i] = vmu_pkg::sat32({{33{s33[32]}}, s33});
                end
            end
            vmu_pkg::OP_MUL, vmu_pkg::OP_DOT: begin
                for (int i = 0; i < 4; i++) begin
                    x0_next[i] = a_in[i];
                    y0_next[i] = b_in[i];
                end
            end
            vmu_pkg::OP_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    x0_next[i] = a_in[i];
                    y0_next[i] = b_in[0];
                end
            end
            vmu_pkg::OP_CROSS: begin
                x0_next[0] = a_in[1]; y0_next[0] = b_in[2];
                x1_next[0] = a_in[2]; y1_next[0] = b_in[1];
                x0_next[1] = a_in[2]; y0_next[1] = b_in[0];
                x1_next[1] = a_in[0]; y1_next[1] = b_in[2];
                x0_next[2] = a_in[0]; y0_next[2] = b_in[1];
                x1_next[2] = a_in[1]; y1_next[2] = b_in[0];
            end
            vmu_pkg::OP_NORM: begin
                // signed square equals the squared magnitude
                for (int i = 0; i < 4; i++) begin
                    x0_next[i] = a_in[i];
                    y0_next[i] = a_in[i];
                end
                a_side_next.nrm = 1'b1;
                unique case (size_in)
                    vmu_pkg::SIZE_2: a_side_next.used = 4'b0011;
                    vmu_pkg::SIZE_3: a_side_next.used = 4'b0111;
                    vmu_pkg::SIZE_4: a_side_next.used = 4'b1111;
                    default:         a_side_next.fault = 1'b1;
                endcase
            end
            default: begin
                // unused opcode: all lanes zero, no fault
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_op_reg   <= s_tuser;
            a_side_reg <= a_side_next;
            for (int i = 0; i < 4; i++) begin
                a_x0_reg[i] <= x0_next[i];
                a_y0_reg[i] <= y0_next[i];
                a_x1_reg[i] <= x1_next[i];
                a_y1_reg[i] <= y1_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: eight 32x32 signed multipliers
    // ------------------------------------------------------------------
    logic               b_vld_reg;
    logic        [2:0]  b_op_reg;
    logic signed [63:0] b_p0_reg [4], b_p1_reg [4];
    vmu_pkg::side_t     b_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_op_reg   <= a_op_reg;
            b_side_reg <= a_side_reg;
            for (int i = 0; i < 4; i++) begin
                b_p0_reg[i] <= a_x0_reg[i] * a_y0_reg[i];
                b_p1_reg[i] <= a_x1_reg[i] * a_y1_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: Q shift, lane differences, first level of dot and sum of squares
    // ------------------------------------------------------------------
    logic signed [63:0] p0s [4], p1s [4];
    logic        [64:0] diff [4];
    vmu_pkg::side_t     c_side_next;

    logic               c_vld_reg;
    logic        [2:0]  c_op_reg;
    logic        [64:0] c_s01_reg, c_s23_reg;
    logic        [63:0] c_q01_reg, c_q23_reg;
    vmu_pkg::side_t     c_side_reg;

    always_comb begin
        c_side_next = b_side_reg;
        for (int i = 0; i < 4; i++) begin
            p0s[i]  = b_p0_reg[i] >>> FRAC_BITS;
            p1s[i]  = b_p1_reg[i] >>> FRAC_BITS;
            diff[i] = {p0s[i][63], p0s[i]} - {p1s[i][63], p1s[i]};
            if (b_op_reg == vmu_pkg::OP_MUL || b_op_reg == vmu_pkg::OP_SCALE ||
                b_op_reg == vmu_pkg::OP_CROSS) begin
                c_side_next.res[i] = vmu_pkg::sat32({diff[i][64], diff[i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_op_reg   <= b_op_reg;
            c_side_reg <= c_side_next;
            c_s01_reg  <= {p0s[0][63], p0s[0]} + {p0s[1][63], p0s[1]};
            c_s23_reg  <= {p0s[2][63], p0s[2]} + {p0s[3][63], p0s[3]};
            c_q01_reg  <= {1'b0, b_p0_reg[0][62:0] & {63{b_side_reg.used[0]}}}
                        + {1'b0, b_p0_reg[1][62:0] & {63{b_side_reg.used[1]}}};
            c_q23_reg  <= {1'b0, b_p0_reg[2][62:0] & {63{b_side_reg.used[2]}}}
                        + {1'b0, b_p0_reg[3][62:0] & {63{b_side_reg.used[3]}}};
        end
    end

    // ------------------------------------------------------------------
    // Stage D: dot total, sum of squares total, zero-magnitude check
    // ------------------------------------------------------------------
    logic [65:0] dot_sum;
    logic [64:0] sumsq;
    vmu_pkg::side_t d_side_next;

    logic                        sq_vld_reg  [vmu_pkg::SQ_STEPS+1];
    vmu_pkg::side_t              sq_side_reg [vmu_pkg::SQ_STEPS+1];
    logic [vmu_pkg::RAD_W-1:0]   sq_rad_reg  [vmu_pkg::SQ_STEPS+1];
    logic [vmu_pkg::REM_W-1:0]   sq_rem_reg  [vmu_pkg::SQ_STEPS+1];
    logic [vmu_pkg::ROOT_W-1:0]  sq_root_reg [vmu_pkg::SQ_STEPS+1];

    always_comb begin
        dot_sum     = {c_s01_reg[64], c_s01_reg} + {c_s23_reg[64], c_s23_reg};
        sumsq       = {1'b0, c_q01_reg} + {1'b0, c_q23_reg};
        d_side_next = c_side_reg;
        if (c_side_reg.nrm && sumsq == '0) begin
            d_side_next.fault = 1'b1;
        end
        if (c_op_reg == vmu_pkg::OP_DOT) begin
            d_side_next.res = {96'd0, vmu_pkg::sat32(dot_sum)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (en) begin
            sq_vld_reg[0] <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_side_reg[0] <= d_side_next;
            sq_rad_reg[0]  <= {1'b0, sumsq};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one restoring root bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < vmu_pkg::SQ_STEPS; k++) begin : g_sqrt
        logic [vmu_pkg::REM_W+1:0]  cand;
        logic [vmu_pkg::REM_W+1:0]  trial;
        logic                       ge;
        logic [vmu_pkg::REM_W-1:0]  rem_next;
        logic [vmu_pkg::ROOT_W-1:0] root_next;

        always_comb begin
            cand      = {sq_rem_reg[k], sq_rad_reg[k][vmu_pkg::RAD_W-1 -: 2]};
            trial     = {1'b0, sq_root_reg[k], 2'b01};
            ge        = cand >= trial;
            rem_next  = ge ? vmu_pkg::REM_W'(cand - trial) : vmu_pkg::REM_W'(cand);
            root_next = {sq_root_reg[k][vmu_pkg::ROOT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][vmu_pkg::RAD_W-3:0], 2'b00};
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Divide: |a| * 2^FRAC_BITS / root, one quotient bit per stage, 4 lanes
    // ------------------------------------------------------------------
    logic                       dv_vld_reg  [QW];
    vmu_pkg::side_t             dv_side_reg [QW];
    logic [vmu_pkg::ROOT_W-1:0] dv_den_reg  [QW];
    logic [vmu_pkg::ROOT_W-1:0] dv_rem_reg  [QW][4];
    logic [QW-1:0]              dv_q_reg    [QW][4];

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic                       vld_in;
        vmu_pkg::side_t             side_in;
        logic [vmu_pkg::ROOT_W-1:0] den_in;
        logic [vmu_pkg::ROOT_W-1:0] rem_in  [4];
        logic [QW-1:0]              q_in    [4];
        logic                       bit_in  [4];
        logic [vmu_pkg::ROOT_W:0]   cand    [4];
        logic [vmu_pkg::ROOT_W-1:0] rem_next [4];
        logic [QW-1:0]              q_next  [4];

        if (j == 0) begin : g_first
            always_comb begin
                vld_in  = sq_vld_reg[vmu_pkg::SQ_STEPS];
                side_in = sq_side_reg[vmu_pkg::SQ_STEPS];
                den_in  = sq_root_reg[vmu_pkg::SQ_STEPS];
                for (int i = 0; i < 4; i++) begin
                    rem_in[i] = {2'b00, side_in.mag[i][31:1]};
                    q_in[i]   = '0;
                    bit_in[i] = side_in.mag[i][0];
                end
            end
        end else begin : g_rest
            always_comb begin
                vld_in  = dv_vld_reg[j-1];
                side_in = dv_side_reg[j-1];
                den_in  = dv_den_reg[j-1];
                for (int i = 0; i < 4; i++) begin
                    rem_in[i] = dv_rem_reg[j-1][i];
                    q_in[i]   = dv_q_reg[j-1][i];
                    bit_in[i] = 1'b0;
                end
            end
        end

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                cand[i] = {rem_in[i], bit_in[i]};
                if (cand[i] >= {1'b0, den_in}) begin
                    rem_next[i] = vmu_pkg::ROOT_W'(cand[i] - {1'b0, den_in});
                    q_next[i]   = {q_in[i][QW-2:0], 1'b1};
                end else begin
                    rem_next[i] = vmu_pkg::ROOT_W'(cand[i]);
                    q_next[i]   = {q_in[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_side_reg[j] <= side_in;
                dv_den_reg[j]  <= den_in;
                for (int i = 0; i < 4; i++) begin
                    dv_rem_reg[j][i] <= rem_next[i];
                    dv_q_reg[j][i]   <= q_next[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sign the quotients, pick lane source, hold for m_tready
    // ------------------------------------------------------------------
    vmu_pkg::side_t    last_side;
    logic [3:0][31:0]  lane_next;
    logic [31:0]       qext;
    logic [127:0]      out_data_reg;
    logic              out_fault_reg;

    always_comb begin
        last_side = dv_side_reg[QW-1];
        for (int i = 0; i < 4; i++) begin
            qext = 32'(dv_q_reg[QW-1][i]);
            if (!last_side.nrm) begin
                lane_next[i] = last_side.res[i];
            end else if (last_side.fault || !last_side.used[i]) begin
                lane_next[i] = '0;
            end else begin
                lane_next[i] = last_side.neg[i] ? (~qext + 32'd1) : qext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_vld_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg  <= lane_next;
            out_fault_reg <= last_side.fault;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fault_reg;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for vector_math_unit
// Drives directed and random vector requests on the slave stream, predicts
// each result beat in the bench or uses a typed answer; checks lane by lane in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRAC      = 16;
    localparam int LAT       = 38 + FRAC + 1;
    localparam int N_RANDOM  = 950;
    localparam int MAX_CYC   = 400000;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] a [4];
        logic [31:0] b [4];
        logic [2:0]  size;
    } vreq_t;

    typedef struct {
        logic [31:0] r [4];
        logic        fault;
    } vres_t;

    // directed row: request plus an optional typed-in answer
    typedef struct {
        vreq_t req;
        bit    fixed;
        vres_t ans;
    } vrow_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [263:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;

    vres_t lane_results_q[$];
    int    n_errors = 0;
    int    n_beats_out = 0;
    int    n_faults = 0;
    int    cyc = 0;
    bit    stim_done = 0;
    bit    hold_off = 0;
    int    op_seen [8];

    vector_math_unit #(.FRAC_BITS(FRAC)) dut (.*);

    always #5 aclk = ~aclk;

    // ---------------- predictor ----------------
    function automatic logic [31:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'h7fff_ffff;
        if (v < -66'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // exact product, arithmetic shift = floor
    function automatic logic signed [65:0] qprod(input logic [31:0] x, input logic [31:0] y);
        logic signed [65:0] p;
        p = $signed({{34{x[31]}}, x}) * $signed({{34{y[31]}}, y});
        return p >>> FRAC;
    endfunction

    function automatic vres_t predict_lanes(input vreq_t q);
        vres_t o;
        logic signed [65:0] s, av, bv;
        logic [66:0] sumsq, mag, t;
        logic [66:0] m, quo;
        o.fault = 1'b0;
        for (int i = 0; i < 4; i++) o.r[i] = '0;
        unique case (q.op)
            vmu_pkg::OP_ADD, vmu_pkg::OP_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    av = 66'($signed(q.a[i]));
                    bv = 66'($signed(q.b[i]));
                    s  = (q.op == vmu_pkg::OP_ADD) ? av + bv : av - bv;
                    o.r[i] = clamp32(s);
                end
            end
            vmu_pkg::OP_MUL:
                for (int i = 0; i < 4; i++) o.r[i] = clamp32(qprod(q.a[i], q.b[i]));
            vmu_pkg::OP_SCALE:
                for (int i = 0; i < 4; i++) o.r[i] = clamp32(qprod(q.a[i], q.b[0]));
            vmu_pkg::OP_CROSS: begin
                o.r[0] = clamp32(qprod(q.a[1], q.b[2]) - qprod(q.a[2], q.b[1]));
                o.r[1] = clamp32(qprod(q.a[2], q.b[0]) - qprod(q.a[0], q.b[2]));
                o.r[2] = clamp32(qprod(q.a[0], q.b[1]) - qprod(q.a[1], q.b[0]));
            end
            vmu_pkg::OP_DOT: begin
                s = '0;
                for (int i = 0; i < 4; i++) s += qprod(q.a[i], q.b[i]);
                o.r[0] = clamp32(s);
            end
            vmu_pkg::OP_NORM: begin
                if (q.size < vmu_pkg::SIZE_2 || q.size > vmu_pkg::SIZE_4) begin
                    o.fault = 1'b1;
                end else begin
                    sumsq = '0;
                    for (int i = 0; i < q.size; i++) begin
                        av = 66'($signed(q.a[i]));
                        m  = 67'((av < 0) ? -av : av);
                        sumsq += m * m;
                    end
                    // bitwise floor square root, root fits 33 bits
                    mag = '0;
                    for (int bt = 32; bt >= 0; bt--) begin
                        t = mag | (67'd1 << bt);
                        if (t * t <= sumsq) mag = t;
                    end
                    if (mag == 0) begin
                        o.fault = 1'b1;
                    end else begin
                        for (int i = 0; i < q.size; i++) begin
                            av  = 66'($signed(q.a[i]));
                            m   = 67'((av < 0) ? -av : av);
                            quo = (m << FRAC) / mag;
                            s   = $signed({1'b0, quo[64:0]});
                            o.r[i] = clamp32(av < 0 ? -s : s);
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [31:0] rand_lane();
        unique case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 3) << 16;     // small integers
            3: return -($urandom_range(0, 3) << 16);
            4: return 32'h0;
            5: return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic vreq_t rand_req();
        vreq_t q;
        q.op = ($urandom_range(0, 49) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
        for (int i = 0; i < 4; i++) begin
            q.a[i] = rand_lane();
            q.b[i] = rand_lane();
        end
        // normalize mostly valid sizes, sometimes bad ones
        q.size = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(2, 4));
        return q;
    endfunction

    function automatic vreq_t mk(input logic [2:0] op, input logic [31:0] av,
                                 input logic [31:0] bv, input logic [2:0] sz);
        vreq_t q;
        q.op = op;
        q.size = sz;
        for (int i = 0; i < 4; i++) begin
            q.a[i] = av;
            q.b[i] = bv;
        end
        return q;
    endfunction

    // one beat on the slave side, with random gaps when allowed
    task automatic send_beat(input vreq_t q, input bit gaps);
        while (gaps && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.op;
        s_tdata  <= {5'd0, q.size, q.b[3], q.b[2], q.b[1], q.b[0],
                     q.a[3], q.a[2], q.a[1], q.a[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        op_seen[q.op]++;
        lane_results_q.push_back(predict_lanes(q));
    endtask

    // ---------------- directed table ----------------
    vrow_t dir_rows[$];

    task automatic add_row(input vreq_t q, input bit fx, input vres_t ans);
        vrow_t rw;
        rw.req = q;
        rw.fixed = fx;
        rw.ans = ans;
        dir_rows.push_back(rw);
    endtask

    function automatic vres_t fix(input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z, input logic [31:0] w,
                                  input logic f);
        vres_t o;
        o.r[0] = x; o.r[1] = y; o.r[2] = z; o.r[3] = w; o.fault = f;
        return o;
    endfunction

    task automatic build_table();
        vres_t nil;
        vreq_t q;
        vres_t flt;
        nil = fix(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        flt = fix(32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        // saturating add/sub at the extremes
        add_row(mk(vmu_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 3'd0), 1'b1,
                fix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        add_row(mk(vmu_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 3'd0), 1'b1,
                fix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        add_row(mk(vmu_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001, 3'd0), 1'b1,
                fix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        add_row(mk(vmu_pkg::OP_SUB, 32'h7fff_ffff, 32'h8000_0000, 3'd0), 1'b1,
                fix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        // 1.0 * 1.0, min*min saturates, floor of a tiny negative product
        add_row(mk(vmu_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000, 3'd0), 1'b1,
                fix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
        add_row(mk(vmu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 3'd0), 1'b1,
                fix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        add_row(mk(vmu_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001, 3'd0), 1'b1,
                fix(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0));
        add_row(mk(vmu_pkg::OP_DOT, 32'h8000_0000, 32'h8000_0000, 3'd0), 1'b1,
                fix(32'h7fff_ffff, 32'd0, 32'd0, 32'd0, 1'b0));
        add_row(mk(vmu_pkg::OP_DOT, 32'h8000_0000, 32'h7fff_ffff, 3'd0), 1'b0, nil);
        add_row(mk(vmu_pkg::OP_SCALE, 32'h7fff_ffff, 32'h8000_0000, 3'd0), 1'b0, nil);
        add_row(mk(vmu_pkg::OP_CROSS, 32'h7fff_ffff, 32'h8000_0000, 3'd0), 1'b0, nil);
        q = mk(vmu_pkg::OP_CROSS, 32'd0, 32'd0, 3'd0);
        q.a[0] = 32'h0001_0000; q.b[1] = 32'h0001_0000;   // x cross y = z
        add_row(q, 1'b1, fix(32'd0, 32'd0, 32'h0001_0000, 32'd0, 1'b0));
        // normalize: bad sizes, zero magnitude, a 3-4-5 case, extremes
        add_row(mk(vmu_pkg::OP_NORM, 32'h0001_0000, 32'd0, 3'd0), 1'b1, flt);
        add_row(mk(vmu_pkg::OP_NORM, 32'h0001_0000, 32'd0, 3'd1), 1'b1, flt);
        add_row(mk(vmu_pkg::OP_NORM, 32'h0001_0000, 32'd0, 3'd5), 1'b1, flt);
        add_row(mk(vmu_pkg::OP_NORM, 32'h0001_0000, 32'd0, 3'd7), 1'b1, flt);
        add_row(mk(vmu_pkg::OP_NORM, 32'h0, 32'hffff_ffff, vmu_pkg::SIZE_4), 1'b1, flt);
        q = mk(vmu_pkg::OP_NORM, 32'd0, 32'd0, vmu_pkg::SIZE_2);
        q.a[0] = 32'h0003_0000; q.a[1] = 32'hfffc_0000; q.a[2] = 32'h1234_5678;
        add_row(q, 1'b1, fix(32'h0000_9999, 32'hffff_3334, 32'd0, 32'd0, 1'b0));
        add_row(mk(vmu_pkg::OP_NORM, 32'h8000_0000, 32'd0, vmu_pkg::SIZE_4), 1'b0, nil);
        add_row(mk(vmu_pkg::OP_NORM, 32'h7fff_ffff, 32'd0, vmu_pkg::SIZE_3), 1'b0, nil);
        // tiny magnitude
        add_row(mk(vmu_pkg::OP_NORM, 32'h0000_0001, 32'd0, vmu_pkg::SIZE_2), 1'b0, nil);
        add_row(mk(vmu_pkg::OP_NORM, 32'hffff_ffff, 32'h1, vmu_pkg::SIZE_4), 1'b0, nil);
        add_row(mk(OP_UNUSED, 32'h7fff_ffff, 32'h7fff_ffff, vmu_pkg::SIZE_4), 1'b1, nil);
    endtask

    // ---------------- result checker ----------------
    task automatic cmp_field(input string nm, input logic [31:0] e, input logic [31:0] g);
        if (e !== g) begin
            $error("%s expected %h got %h", nm, e, g);
            n_errors++;
        end
    endtask

    always @(posedge aclk) begin
        vres_t e;
        cyc <= cyc + 1;
        if (aresetn && m_tvalid && m_tready) begin
            n_beats_out++;
            if (m_tuser) n_faults++;
            if (lane_results_q.size() == 0) begin
                $error("result beat with nothing pending");
                n_errors++;
            end else begin
                e = lane_results_q.pop_front();
                cmp_field("r_x", e.r[0], m_tdata[31:0]);
                cmp_field("r_y", e.r[1], m_tdata[63:32]);
                cmp_field("r_z", e.r[2], m_tdata[95:64]);
                cmp_field("r_w", e.r[3], m_tdata[127:96]);
                cmp_field("fault", 32'(e.fault), 32'(m_tuser));
            end
        end
    end

    // receiver: random stalls; long clean stretch; one long hold-off
    initial begin
        int k;
        k = 0;
        @(posedge aclk iff aresetn);
        forever begin
            k++;
            if (k == 300) begin
                m_tready <= 1'b0;
                repeat (3 * LAT) @(posedge aclk);   // let the pipe fill and stall input
            end
            if (k > 500 && k < 900) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 99) >= 34);
            @(posedge aclk);
        end
    end

    // timeout guard
    always @(posedge aclk) begin
        if (cyc >= MAX_CYC) begin
            $display("timeout after %0d cycles", cyc);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // main sequence
    initial begin
        vreq_t q;
        int idle;
        build_table();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows; typed answers replace the prediction
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].req, 1'b0);
            if (dir_rows[i].fixed) begin
                void'(lane_results_q.pop_back());
                lane_results_q.push_back(dir_rows[i].ans);
            end
        end

        // random traffic; gaps skipped in a middle window
        for (int n = 0; n < N_RANDOM; n++) begin
            q = rand_req();
            send_beat(q, !(n > 400 && n < 700));
        end
        s_tvalid <= 1'b0;

        idle = 0;
        while (lane_results_q.size() != 0 && idle < 20 * LAT) begin
            @(posedge aclk);
            idle++;
        end
        repeat (LAT + 10) @(posedge aclk);

        $display("covered %0d requests (%0d add, %0d sub, %0d mul, %0d cross, %0d dot,",
                 dir_rows.size() + N_RANDOM, op_seen[vmu_pkg::OP_ADD],
                 op_seen[vmu_pkg::OP_SUB], op_seen[vmu_pkg::OP_MUL],
                 op_seen[vmu_pkg::OP_CROSS], op_seen[vmu_pkg::OP_DOT]);
        $display("  %0d scale, %0d normalize, %0d unused); %0d beats back, %0d faults",
                 op_seen[vmu_pkg::OP_SCALE], op_seen[vmu_pkg::OP_NORM], op_seen[OP_UNUSED],
                 n_beats_out, n_faults);
        if (n_errors == 0 && lane_results_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
